// File: rtl/core/mi3_pkg.sv
// types and constants for the 3x3 adjugate inverse pipeline
// no dependencies; imported by matrix3x3_inverse_top
package mi3_pkg;

    localparam int EW = 32;          // element width, Q16.16
    localparam int PW = 64;          // 2x2 product width
    localparam int CW = 65;          // cofactor width, signed
    localparam int DW = 100;         // determinant and divisor width
    localparam int DIV_STEPS = 32;   // one quotient bit per stage
    localparam int LAT = 9 + DIV_STEPS;

    localparam logic [EW-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [EW-1:0] SAT_NEG = 32'h8000_0000;

    // cofactor k = (m[P]*m[S] - m[Q]*m[T]), negated where COF_NEG is set,
    // k in adjugate order row*3+col
    localparam int COF_P [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
    localparam int COF_S [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
    localparam int COF_Q [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
    localparam int COF_T [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
    localparam bit COF_NEG [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    typedef struct packed {
        logic signed [EW-1:0] a_r0c0;
        logic signed [EW-1:0] a_r0c1;
        logic signed [EW-1:0] a_r0c2;
        logic signed [EW-1:0] a_r1c0;
        logic signed [EW-1:0] a_r1c1;
        logic signed [EW-1:0] a_r1c2;
        logic signed [EW-1:0] a_r2c0;
        logic signed [EW-1:0] a_r2c1;
        logic signed [EW-1:0] a_r2c2;
    } matrix_in_t;

    typedef struct packed {
        logic signed [EW-1:0] inv_r0c0;
        logic signed [EW-1:0] inv_r0c1;
        logic signed [EW-1:0] inv_r0c2;
        logic signed [EW-1:0] inv_r1c0;
        logic signed [EW-1:0] inv_r1c1;
        logic signed [EW-1:0] inv_r1c2;
        logic signed [EW-1:0] inv_r2c0;
        logic signed [EW-1:0] inv_r2c1;
        logic signed [EW-1:0] inv_r2c2;
        logic                 singular;
    } matrix_out_t;

endpackage

// File: rtl/core/matrix3x3_inverse_top.sv
// 3x3 matrix inverse by the adjugate method, fully pipelined
// depends on mi3_pkg for payload types, widths and the cofactor table

// A new matrix may be started in every cycle: busy is always low, and each
// result appears on result with done high for one cycle, after its start
// transfer passes 8 stages of products, cofactors and determinant, 32
// stages of the restoring divider at one quotient bit per stage and one
// output stage. Results come back in start order and cannot be held off,
// so the receiver must take them when done is high. A zero determinant
// gives singular set and all elements zero; other quotients truncate toward
// zero and saturate to the Q16.16 range.
module matrix3x3_inverse_top
    import mi3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  matrix_in_t  operand,
    output logic        done,
    output matrix_out_t result
);

    logic signed [EW-1:0] a_in [9];
    logic [LAT-1:0]       vld_reg;

    logic signed [EW-1:0] m_reg [9];
    logic signed [PW-1:0] pa_reg [9];
    logic signed [PW-1:0] pb_reg [9];
    logic signed [EW-1:0] row1_reg [3];
    logic signed [EW-1:0] row2_reg [3];
    logic signed [CW-1:0] cof2_reg [9];
    logic signed [CW-1:0] cof3_reg [9];
    logic signed [CW-1:0] cof4_reg [9];
    logic signed [CW-1:0] cof5_reg [9];
    logic signed [PW-1:0] ph_reg [3];
    logic signed [PW+1:0] pl_reg [3];
    logic signed [DW-1:0] term_reg [3];
    logic signed [DW-1:0] det_reg;

    logic [CW-1:0]        cmag_reg [9];
    logic                 csgn_reg [9];
    logic [DW-1:0]        dmag6_reg;
    logic                 dsgn_reg;
    logic                 zero6_reg;

    logic [DW-1:0]        r_reg [0:DIV_STEPS][9];
    logic [EW-1:0]        q_reg [0:DIV_STEPS][9];
    logic                 neg_reg [0:DIV_STEPS][9];
    logic                 ovf_reg [0:DIV_STEPS][9];
    logic [DW-1:0]        dmag_reg [0:DIV_STEPS];
    logic                 zero_reg [0:DIV_STEPS];
    logic [DW-1:0]        r_next [DIV_STEPS][9];
    logic                 qb_next [DIV_STEPS][9];

    logic signed [EW-1:0] inv_next [9];
    matrix_out_t          result_reg;

    assign a_in[0] = operand.a_r0c0;
    assign a_in[1] = operand.a_r0c1;
    assign a_in[2] = operand.a_r0c2;
    assign a_in[3] = operand.a_r1c0;
    assign a_in[4] = operand.a_r1c1;
    assign a_in[5] = operand.a_r1c2;
    assign a_in[6] = operand.a_r2c0;
    assign a_in[7] = operand.a_r2c1;
    assign a_in[8] = operand.a_r2c2;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    // input, products, cofactors
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            m_reg[i]    <= a_in[i];
            pa_reg[i]   <= m_reg[COF_P[i]] * m_reg[COF_S[i]];
            pb_reg[i]   <= m_reg[COF_Q[i]] * m_reg[COF_T[i]];
            if (COF_NEG[i])
                cof2_reg[i] <= {pb_reg[i][PW-1], pb_reg[i]} - {pa_reg[i][PW-1], pa_reg[i]};
            else
                cof2_reg[i] <= {pa_reg[i][PW-1], pa_reg[i]} - {pb_reg[i][PW-1], pb_reg[i]};
            cof3_reg[i] <= cof2_reg[i];
            cof4_reg[i] <= cof3_reg[i];
            cof5_reg[i] <= cof4_reg[i];
        end
        for (int j = 0; j < 3; j++)
        begin
            row1_reg[j] <= m_reg[j];
            row2_reg[j] <= row1_reg[j];
        end
    end

    // determinant: row 0 times adjugate column 0, cofactor split 32 + 33 bits
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            ph_reg[j]   <= row2_reg[j] * $signed(cof2_reg[3*j][CW-1:33]);
            pl_reg[j]   <= row2_reg[j] * $signed({1'b0, cof2_reg[3*j][32:0]});
            term_reg[j] <= $signed({{3{ph_reg[j][PW-1]}}, ph_reg[j], 33'd0})
                         + $signed({{(DW-PW-2){pl_reg[j][PW+1]}}, pl_reg[j]});
        end
        det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
    end

    // magnitudes and signs
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            csgn_reg[i] <= cof5_reg[i][CW-1];
            cmag_reg[i] <= cof5_reg[i][CW-1] ? CW'(-cof5_reg[i]) : CW'(cof5_reg[i]);
        end
        dsgn_reg  <= det_reg[DW-1];
        dmag6_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        zero6_reg <= (det_reg == '0);
    end

    // divider entry: |c| >= |d| means the quotient needs more than 32 bits
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            r_reg[0][i]   <= {{(DW-CW){1'b0}}, cmag_reg[i]};
            ovf_reg[0][i] <= ({{(DW-CW){1'b0}}, cmag_reg[i]} >= dmag6_reg);
            neg_reg[0][i] <= csgn_reg[i] ^ dsgn_reg;
            q_reg[0][i]   <= '0;
        end
        dmag_reg[0] <= dmag6_reg;
        zero_reg[0] <= zero6_reg;
    end

    // restoring division, one bit per stage; low numerator bits are zero
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        always_comb
        begin
            for (int i = 0; i < 9; i++)
            begin
                qb_next[k][i] = ({r_reg[k][i], 1'b0} >= {1'b0, dmag_reg[k]});
                r_next[k][i]  = qb_next[k][i]
                              ? DW'({r_reg[k][i], 1'b0} - {1'b0, dmag_reg[k]})
                              : {r_reg[k][i][DW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 9; i++)
            begin
                r_reg[k+1][i]   <= r_next[k][i];
                q_reg[k+1][i]   <= {q_reg[k][i][EW-2:0], qb_next[k][i]};
                neg_reg[k+1][i] <= neg_reg[k][i];
                ovf_reg[k+1][i] <= ovf_reg[k][i];
            end
            dmag_reg[k+1] <= dmag_reg[k];
            zero_reg[k+1] <= zero_reg[k];
        end
    end

    // sign, saturation, singular case
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            if (zero_reg[DIV_STEPS])
                inv_next[i] = '0;
            else if (neg_reg[DIV_STEPS][i])
                inv_next[i] = (ovf_reg[DIV_STEPS][i] || q_reg[DIV_STEPS][i] > SAT_NEG)
                            ? SAT_NEG : EW'(-q_reg[DIV_STEPS][i]);
            else
                inv_next[i] = (ovf_reg[DIV_STEPS][i] || q_reg[DIV_STEPS][i] > SAT_POS)
                            ? SAT_POS : q_reg[DIV_STEPS][i];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.inv_r0c0 <= inv_next[0];
        result_reg.inv_r0c1 <= inv_next[1];
        result_reg.inv_r0c2 <= inv_next[2];
        result_reg.inv_r1c0 <= inv_next[3];
        result_reg.inv_r1c1 <= inv_next[4];
        result_reg.inv_r1c2 <= inv_next[5];
        result_reg.inv_r2c0 <= inv_next[6];
        result_reg.inv_r2c1 <= inv_next[7];
        result_reg.inv_r2c2 <= inv_next[8];
        result_reg.singular <= zero_reg[DIV_STEPS];
    end

    assign result = result_reg;
    assign done   = vld_reg[LAT-1];

    // every result traces back to a start transfer a fixed latency earlier
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without matching start transfer");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.singular) |-> (result.inv_r0c0 == 0 && result.inv_r1c1 == 0
            && result.inv_r2c2 == 0 && result.inv_r0c1 == 0 && result.inv_r2c0 == 0))
        else $error("singular result with nonzero elements");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[LAT-2] && !zero_reg[DIV_STEPS] && ovf_reg[DIV_STEPS][0])
            |=> (result.inv_r0c0 == $signed(SAT_POS) || result.inv_r0c0 == $signed(SAT_NEG)))
        else $error("overflowed quotient not saturated");

endmodule
